@@ rtl/ddodo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddodo_pkg
// Shared types, constants and tables for the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddodo_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int ITER_W            = 5;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [63:0] RAD2BAM_Q16 = 64'd44798133900175;
  localparam logic [63:0] US_PER_S    = 64'd1000000;
  localparam logic [31:0] MIN_DT_US   = 32'd1000;

  localparam logic [31:0] MPT_RESET = 32'd14316558;
  localparam logic [31:0] ITW_RESET = 32'd47934904;

  // register index as seen on paddr[2]
  localparam logic REG_MPT = 1'b0;
  localparam logic REG_ITW = 1'b1;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ang;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cs;
    logic signed [33:0] sn;
  } cordic_res_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_bam(input logic [ITER_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/differential_drive_odometry_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Wheel odometry with midpoint integration: pose, yaw quaternion, velocities.
//
//   channel  direction  handshake          contents
//   in_      input      in_valid/in_stall  wheel counts, dirs, valids, time
//   out_     output     out_valid/out_stall pose, quaternion, speeds
//   apb      input      psel/penable       meters_per_tick, inverse_track_width
//
// An integrating request makes up to nine passes through the shared
// byte-serial multiplier, two 24-step CORDIC runs and up to two restoring
// divisions by dt. Ignored and seeding requests leave the sequencer idle and
// do not raise in_stall. in_stall is high while a request is in work; a result
// waiting on out_stall does not block the next request until its final write.
// Reset is synchronous; config returns to defaults, pose and seed are cleared.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_left_count,
  input  logic [31:0]        in_right_count,
  input  logic               in_left_forward,
  input  logic               in_right_forward,
  input  logic               in_left_valid,
  input  logic               in_right_valid,
  input  logic [31:0]        in_arrival_time_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_pos_x,
  output logic signed [47:0] out_pos_y,
  output logic signed [31:0] out_heading,
  output logic signed [17:0] out_quat_z,
  output logic signed [17:0] out_quat_w,
  output logic signed [31:0] out_linear_speed,
  output logic signed [31:0] out_turn_rate,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ddodo_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PREP  = 5'd1;
  localparam logic [4:0] S_MC    = 5'd2;
  localparam logic [4:0] S_MC_W  = 5'd3;
  localparam logic [4:0] S_MD    = 5'd4;
  localparam logic [4:0] S_MD_W  = 5'd5;
  localparam logic [4:0] S_MA    = 5'd6;
  localparam logic [4:0] S_MA_W  = 5'd7;
  localparam logic [4:0] S_MS    = 5'd8;
  localparam logic [4:0] S_MS_W  = 5'd9;
  localparam logic [4:0] S_C1    = 5'd10;
  localparam logic [4:0] S_C1_W  = 5'd11;
  localparam logic [4:0] S_MX    = 5'd12;
  localparam logic [4:0] S_MX_W  = 5'd13;
  localparam logic [4:0] S_MY    = 5'd14;
  localparam logic [4:0] S_MY_W  = 5'd15;
  localparam logic [4:0] S_C2    = 5'd16;
  localparam logic [4:0] S_C2_W  = 5'd17;
  localparam logic [4:0] S_MT    = 5'd18;
  localparam logic [4:0] S_MT_W  = 5'd19;
  localparam logic [4:0] S_R_CHK = 5'd20;
  localparam logic [4:0] S_R_MW  = 5'd21;
  localparam logic [4:0] S_R_DIV = 5'd22;
  localparam logic [4:0] S_R_SAT = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;

  function automatic logic [17:0] to_q16(input logic signed [33:0] v);
    logic signed [34:0] s;
    logic signed [20:0] r;
    s = 35'(v) + 35'sd8192;
    r = 21'(s >>> 14);
    if (r > 21'sd65536) r = 21'sd65536;
    if (r < -21'sd65536) r = -21'sd65536;
    return r[17:0];
  endfunction

  // config
  logic [31:0] mpt_r, itw_r;
  logic        cfg_wr;

  // state
  logic [4:0]  state_r, state_nxt;
  logic        seeded_r;
  logic [31:0] last_l_r, last_r_r, last_t_r;
  logic [47:0] acc_x_r, acc_y_r;
  logic [31:0] acc_h_r;

  // work registers
  logic signed [32:0] dl_r, dr_r;
  logic [31:0]        dt_r;
  logic [32:0]        smag_r, dmag_r;
  logic               sneg_r, dneg_r;
  logic [63:0]        cen_r, dif_r, apm_r;
  logic [31:0]        step_r, mid_r;
  logic signed [33:0] cs_r, sn_r;
  logic [17:0]        qz_r, qw_r;
  logic [43:0]        tq_r;
  logic               rsel_r;
  logic [63:0]        dq_r;
  logic [31:0]        rem_r;
  logic [5:0]         dcnt_r;
  logic [31:0]        lin_r, turn_r;

  // outputs
  logic               out_valid_r;
  logic [47:0]        o_x_r, o_y_r;
  logic [31:0]        o_h_r, o_lin_r, o_turn_r;
  logic [17:0]        o_qz_r, o_qw_r;

  logic               mul_done;
  logic [127:0]       prod;
  mul_req_t           mreq;
  cordic_req_t        creq;
  cordic_res_t        cres;

  ddodo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mreq),
    .done_o(mul_done),
    .prod_o(prod)
  );

  ddodo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (creq),
    .res_o (cres)
  );

  // combinational helpers
  logic               in_acc;
  logic [31:0]        dlw, drw, dtw;
  logic signed [32:0] dl33, dr33;
  logic signed [33:0] sum, difs;
  logic [33:0]        sabs, dabs;
  logic [33:0]        abs_cs, abs_sn;
  logic [32:0]        step33;
  logic [43:0]        q16_l;
  logic [43:0]        q16;
  logic               big;
  logic [32:0]        rem_sh;
  logic               ge;
  logic [63:0]        sat;
  logic               rneg;
  logic [31:0]        rres;
  logic               out_load;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign dlw  = in_left_count - last_l_r;
  assign drw  = in_right_count - last_r_r;
  assign dtw  = in_arrival_time_us - last_t_r;
  assign dl33 = in_left_forward  ? signed'({dlw[31], dlw}) : -signed'({dlw[31], dlw});
  assign dr33 = in_right_forward ? signed'({drw[31], drw}) : -signed'({drw[31], drw});

  assign sum  = 34'(dl_r) + 34'(dr_r);
  assign difs = 34'(dr_r) - 34'(dl_r);
  assign sabs = sum[33]  ? 34'(-sum)  : 34'(sum);
  assign dabs = difs[33] ? 34'(-difs) : 34'(difs);

  assign abs_cs = cs_r[33] ? 34'(-cs_r) : 34'(cs_r);
  assign abs_sn = sn_r[33] ? 34'(-sn_r) : 34'(sn_r);

  assign step33 = dneg_r ? 33'(-prod[88:56]) : prod[88:56];

  assign q16_l = cen_r[60:17];
  assign q16   = rsel_r ? tq_r : q16_l;
  assign big   = rsel_r ? tq_r[43] : (cen_r[63:60] != 4'd0);

  assign rem_sh = {rem_r, dq_r[63]};
  assign ge     = rem_sh >= {1'b0, dt_r};

  assign rneg = rsel_r ? dneg_r : sneg_r;
  always_comb begin
    if (rneg) begin
      sat  = (dq_r > 64'h80000000) ? 64'h80000000 : dq_r;
      rres = 32'(-sat[31:0]);
    end else begin
      sat  = (dq_r > 64'h7FFFFFFF) ? 64'h7FFFFFFF : dq_r;
      rres = sat[31:0];
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // unit requests
  always_comb begin
    mreq = '0;
    creq = '0;
    unique case (state_r)
      S_MC: begin
        mreq = '{start: 1'b1, a: 64'(smag_r), b: 64'(mpt_r)};
      end
      S_MD: begin
        mreq = '{start: 1'b1, a: 64'(dmag_r), b: 64'(mpt_r)};
      end
      S_MA: begin
        mreq = '{start: 1'b1, a: 64'(itw_r), b: RAD2BAM_Q16};
      end
      S_MS: begin
        mreq = '{start: 1'b1, a: dif_r, b: apm_r};
      end
      S_MX: begin
        mreq = '{start: 1'b1, a: {9'd0, cen_r[63:9]}, b: 64'(abs_cs)};
      end
      S_MY: begin
        mreq = '{start: 1'b1, a: {9'd0, cen_r[63:9]}, b: 64'(abs_sn)};
      end
      S_MT: begin
        mreq = '{start: 1'b1, a: dif_r, b: 64'(itw_r)};
      end
      S_R_CHK: begin
        mreq = '{start: !big, a: 64'(q16), b: US_PER_S};
      end
      S_C1: begin
        creq = '{start: 1'b1, ang: mid_r};
      end
      S_C2: begin
        // half of the signed heading
        creq = '{start: 1'b1, ang: {acc_h_r[31], acc_h_r[31:1]}};
      end
      default: begin
        mreq = '0;
        creq = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_left_valid && in_right_valid && seeded_r) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_MC;
      S_MC:    state_nxt = S_MC_W;
      S_MC_W:  if (mul_done) state_nxt = S_MD;
      S_MD:    state_nxt = S_MD_W;
      S_MD_W:  if (mul_done) state_nxt = S_MA;
      S_MA:    state_nxt = S_MA_W;
      S_MA_W:  if (mul_done) state_nxt = S_MS;
      S_MS:    state_nxt = S_MS_W;
      S_MS_W:  if (mul_done) state_nxt = S_C1;
      S_C1:    state_nxt = S_C1_W;
      S_C1_W:  if (cres.done) state_nxt = S_MX;
      S_MX:    state_nxt = S_MX_W;
      S_MX_W:  if (mul_done) state_nxt = S_MY;
      S_MY:    state_nxt = S_MY_W;
      S_MY_W:  if (mul_done) state_nxt = S_C2;
      S_C2:    state_nxt = S_C2_W;
      S_C2_W:  if (cres.done) state_nxt = S_MT;
      S_MT:    state_nxt = S_MT_W;
      S_MT_W:  if (mul_done) state_nxt = S_R_CHK;
      S_R_CHK: state_nxt = big ? S_R_SAT : S_R_MW;
      S_R_MW:  if (mul_done) state_nxt = S_R_DIV;
      S_R_DIV: if (dcnt_r == 6'd63) state_nxt = S_R_SAT;
      S_R_SAT: state_nxt = rsel_r ? S_OUT : S_R_CHK;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seeded_r    <= 1'b0;
      last_l_r    <= '0;
      last_r_r    <= '0;
      last_t_r    <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
      mpt_r       <= MPT_RESET;
      itw_r       <= ITW_RESET;
      out_valid_r <= 1'b0;
      rsel_r      <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        if (paddr[2] == REG_MPT) mpt_r <= pwdata;
        if (paddr[2] == REG_ITW) itw_r <= pwdata;
      end

      if (in_acc && in_left_valid && in_right_valid) begin
        seeded_r <= 1'b1;
        last_l_r <= in_left_count;
        last_r_r <= in_right_count;
        last_t_r <= in_arrival_time_us;
      end

      if (state_r == S_MX_W && mul_done) begin
        if (sneg_r ^ cs_r[33]) acc_x_r <= acc_x_r - prod[77:30];
        else                   acc_x_r <= acc_x_r + prod[77:30];
      end
      if (state_r == S_MY_W && mul_done) begin
        if (sneg_r ^ sn_r[33]) acc_y_r <= acc_y_r - prod[77:30];
        else                   acc_y_r <= acc_y_r + prod[77:30];
        acc_h_r <= acc_h_r + step_r;
      end

      if (state_r == S_MT_W) rsel_r <= 1'b0;
      if (state_r == S_R_SAT) rsel_r <= 1'b1;

      if (state_r == S_R_MW) dcnt_r <= '0;
      else if (state_r == S_R_DIV) dcnt_r <= dcnt_r + 1'b1;

      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end

    // payload
    if (in_acc) begin
      dl_r <= dl33;
      dr_r <= dr33;
      dt_r <= (dtw < MIN_DT_US) ? MIN_DT_US : dtw;
    end
    if (state_r == S_PREP) begin
      smag_r <= sabs[32:0];
      dmag_r <= dabs[32:0];
      sneg_r <= sum[33];
      dneg_r <= difs[33];
    end
    if (state_r == S_MC_W && mul_done) cen_r <= prod[63:0];
    if (state_r == S_MD_W && mul_done) dif_r <= prod[63:0];
    if (state_r == S_MA_W && mul_done) apm_r <= prod[79:16];
    if (state_r == S_MS_W && mul_done) begin
      step_r <= step33[31:0];
      mid_r  <= acc_h_r + step33[32:1];
    end
    if (state_r == S_C1_W && cres.done) begin
      cs_r <= cres.cs;
      sn_r <= cres.sn;
    end
    if (state_r == S_C2_W && cres.done) begin
      qw_r <= to_q16(cres.cs);
      qz_r <= to_q16(cres.sn);
    end
    if (state_r == S_MT_W && mul_done) begin
      tq_r <= (prod[127:83] != '0) ? 44'h800_0000_0000 : {1'b0, prod[82:40]};
    end
    if (state_r == S_R_CHK && big) dq_r <= 64'h100_0000_0000;
    if (state_r == S_R_MW && mul_done) begin
      dq_r  <= prod[63:0];
      rem_r <= '0;
    end
    if (state_r == S_R_DIV) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, dt_r}) : rem_sh[31:0];
      dq_r  <= {dq_r[62:0], ge};
    end
    if (state_r == S_R_SAT) begin
      if (rsel_r) turn_r <= rres;
      else        lin_r  <= rres;
    end
    if (out_load) begin
      o_x_r    <= acc_x_r;
      o_y_r    <= acc_y_r;
      o_h_r    <= acc_h_r;
      o_qz_r   <= qz_r;
      o_qw_r   <= qw_r;
      o_lin_r  <= lin_r;
      o_turn_r <= turn_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = signed'(o_x_r);
  assign out_pos_y        = signed'(o_y_r);
  assign out_heading      = signed'(o_h_r);
  assign out_quat_z       = signed'(o_qz_r);
  assign out_quat_w       = signed'(o_qw_r);
  assign out_linear_speed = signed'(o_lin_r);
  assign out_turn_rate    = signed'(o_turn_r);

  assign prdata = (paddr[2] == REG_ITW) ? itw_r : mpt_r;
  assign pready = 1'b1;

endmodule

@@ rtl/ddodo_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddodo_mul
// Shared 64x64 unsigned multiplier, one byte of b per cycle, 128-bit product.
// ----------------------------------------------------------------------------
module ddodo_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  ddodo_pkg::mul_req_t req_i,
  output logic               done_o,
  output logic [127:0]       prod_o
);
  import ddodo_pkg::*;

  localparam int DIGIT = 8;
  localparam int STEPS = 64 / DIGIT;
  localparam int CNT_W = $clog2(STEPS);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [63:0]        a_r, a_nxt, b_r, b_nxt;
  logic [127:0]       acc_r, acc_nxt;
  logic [63+DIGIT:0]  pp;

  assign pp = a_r * b_r[63 -: DIGIT];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = req_i.a;
      b_nxt    = req_i.b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      // MSB digit first: shift accumulated sum up, add next partial product
      acc_nxt = (acc_r << DIGIT) + {{(128-64-DIGIT){1'b0}}, pp};
      b_nxt   = b_r << DIGIT;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done_o = done_r;
  assign prod_o = acc_r;

endmodule

@@ rtl/ddodo_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddodo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q.30 sin/cos.
// ----------------------------------------------------------------------------
module ddodo_cordic (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ddodo_pkg::cordic_req_t req_i,
  output ddodo_pkg::cordic_res_t res_o
);
  import ddodo_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               flip_r, flip_nxt;
  logic [ITER_W-1:0]  i_r, i_nxt;
  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [33:0] xs, ys, at;
  logic               fl;
  logic [31:0]        a2;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = signed'({2'b00, atan_bam(i_r)});
  // quadrants 1 and 2 are folded by a half turn
  assign fl = req_i.ang[31] ^ req_i.ang[30];
  assign a2 = req_i.ang ^ {fl, 31'd0};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    flip_nxt = flip_r;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      flip_nxt = fl;
      i_nxt    = '0;
      x_nxt    = CORDIC_GAIN_Q30;
      y_nxt    = '0;
      z_nxt    = signed'({{2{a2[31]}}, a2});
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == ITER_W'(CORDIC_ITERATIONS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign res_o.done = done_r;
  assign res_o.cs   = flip_r ? -x_r : x_r;
  assign res_o.sn   = flip_r ? -y_r : y_r;

endmodule
